>>> rtl/ubds_pkg.sv
// ubds_pkg: shared widths, constants, status codes and sequencer states
// for the uart baud divisor search block; no dependencies
`timescale 1ns / 1ps

package ubds_pkg;

  // field widths
  localparam int KHZ_W    = 16;
  localparam int BAUD_W   = 22;
  localparam int STATUS_W = 2;
  localparam int OSR_W    = 5;
  localparam int DIVOUT_W = 13;

  // internal widths: clock in hz reaches 50e6, divisor reaches 50e6 / 4
  localparam int CLK_HZ_W = 26;
  localparam int DV_W     = 24;
  localparam int TOL_W    = BAUD_W;

  // clock range and scaling
  localparam int CLK_KHZ_MIN   = 32;
  localparam int CLK_KHZ_MAX   = 50000;
  localparam int HZ_PER_KHZ    = 1000;
  localparam int TOL_DIV       = 100;
  localparam int TOL_MUL       = 3;
  localparam int BOTH_EDGE_MIN = 4;
  localparam int BOTH_EDGE_MAX = 8;

  // parameter defaults
  localparam int MIN_RATIO_DEF = 4;
  localparam int MAX_RATIO_DEF = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CLK_RANGE = 2'd1,
    ST_NO_FIT    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOL_START,
    S_TOL_WAIT,
    S_MUL_DEN,
    S_DV_START,
    S_DV_WAIT,
    S_MUL_GOT,
    S_GOT_START,
    S_GOT_WAIT,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/uart_baud_divisor_search.sv
// uart_baud_divisor_search: out_valid rises once every ratio MIN_RATIO..MAX_RATIO (4..32 at
// the defaults) is tried, sooner when ratios are skipped; one request at a time, the next
// taken only after the result is taken. the serial divider (two divisions per ratio, one
// more for the tolerance) sets the search time; a clock out of range skips the search and
// gives out_valid in the cycle after accept. in_stall is high from accept until the result
// is taken. synchronous active-low reset returns to idle, no result pending.
`timescale 1ns / 1ps

// top level: sequencer, shared small multiplier and search registers
// depends on ubds_pkg and ubds_serial_div
module uart_baud_divisor_search import ubds_pkg::*; #(
  parameter int MIN_RATIO = MIN_RATIO_DEF,
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KHZ_W-1:0]    in_clock_khz,
  input  logic [BAUD_W-1:0]   in_target_baud,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [OSR_W-1:0]    out_osr_field,
  output logic [DIVOUT_W-1:0] out_divisor,
  output logic                out_both_edge,
  output logic                out_enable
);

  // ratio counter holds up to MAX_RATIO
  localparam int RW     = $clog2(MAX_RATIO + 1);
  // multiplier product: baud * ratio or divisor * ratio
  localparam int PROD_W = DV_W + RW;

  state_t state_r, state_nxt;

  logic [CLK_HZ_W-1:0] clk_hz_r, clk_hz_nxt;
  logic [BAUD_W-1:0]   baud_r, baud_nxt;
  logic [RW-1:0]       ratio_r, ratio_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DV_W-1:0]     dv_r, dv_nxt;
  logic [TOL_W-1:0]    tol_r, tol_nxt;
  logic [CLK_HZ_W-1:0] best_err_r, best_err_nxt;
  logic [RW-1:0]       best_ratio_r, best_ratio_nxt;
  logic [DV_W-1:0]     best_dv_r, best_dv_nxt;
  logic                found_r, found_nxt;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OSR_W-1:0]    osr_r, osr_nxt;
  logic [DIVOUT_W-1:0] divout_r, divout_nxt;
  logic                both_edge_r, both_edge_nxt;
  logic                enable_r, enable_nxt;

  // shared divider
  logic                div_start;
  logic [CLK_HZ_W-1:0] div_num;
  logic [PROD_W-1:0]   div_den;
  logic [CLK_HZ_W-1:0] div_quo;
  div_stat_t           div_st;

  // shared multiplier operand
  logic [DV_W-1:0]     mul_a;

  // error of the current ratio
  logic [CLK_HZ_W-1:0] baud_ext;
  logic [CLK_HZ_W-1:0] cur_err;
  logic                clk_bad;
  logic [RW-1:0]       osr_tmp;
  logic                fit_ok;

  ubds_serial_div #(
    .NUM_W (CLK_HZ_W),
    .DEN_W (PROD_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_st)
  );

  // tolerance pass divides the baud by 100, every other pass divides the clock
  assign div_num = (state_r == S_TOL_START) ? CLK_HZ_W'(baud_r) : clk_hz_r;
  assign div_den = (state_r == S_TOL_START) ? PROD_W'(TOL_DIV) : prod_r;

  // multiplier input: baud for the denominator, divisor for the achieved rate
  assign mul_a = (state_r == S_MUL_GOT) ? dv_r : DV_W'(baud_r);

  assign baud_ext = CLK_HZ_W'(baud_r);
  assign cur_err  = (div_quo > baud_ext) ? (div_quo - baud_ext) : (baud_ext - div_quo);

  assign clk_bad = (in_clock_khz < KHZ_W'(CLK_KHZ_MIN)) ||
                   (in_clock_khz > KHZ_W'(CLK_KHZ_MAX));

  assign osr_tmp = best_ratio_r - RW'(1);
  assign fit_ok  = found_r && (best_err_r < CLK_HZ_W'(tol_r));

  always_comb begin
    state_nxt      = state_r;
    clk_hz_nxt     = clk_hz_r;
    baud_nxt       = baud_r;
    ratio_nxt      = ratio_r;
    prod_nxt       = prod_r;
    dv_nxt         = dv_r;
    tol_nxt        = tol_r;
    best_err_nxt   = best_err_r;
    best_ratio_nxt = best_ratio_r;
    best_dv_nxt    = best_dv_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    osr_nxt        = osr_r;
    divout_nxt     = divout_r;
    both_edge_nxt  = both_edge_r;
    enable_nxt     = enable_r;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          clk_hz_nxt = CLK_HZ_W'({10'd0, in_clock_khz} * CLK_HZ_W'(HZ_PER_KHZ));
          baud_nxt   = in_target_baud;
          found_nxt  = 1'b0;
          ratio_nxt  = RW'(MIN_RATIO);
          if (clk_bad) begin
            // clock out of range: no search
            status_nxt    = ST_CLK_RANGE;
            osr_nxt       = '0;
            divout_nxt    = '0;
            both_edge_nxt = 1'b0;
            enable_nxt    = 1'b0;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_TOL_START;
          end
        end
      end
      S_TOL_START: begin
        div_start = 1'b1;
        state_nxt = S_TOL_WAIT;
      end
      S_TOL_WAIT: begin
        if (div_st.done) begin
          tol_nxt   = TOL_W'(div_quo[TOL_W-1:0] * TOL_W'(TOL_MUL));
          state_nxt = S_MUL_DEN;
        end
      end
      S_MUL_DEN: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(ratio_r);
        state_nxt = S_DV_START;
      end
      S_DV_START: begin
        // zero baud gives a zero denominator: skip the ratio
        if (prod_r == '0) begin
          state_nxt = S_NEXT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DV_WAIT;
        end
      end
      S_DV_WAIT: begin
        if (div_st.done) begin
          dv_nxt = div_quo[DV_W-1:0];
          // zero divisor: ratio unusable
          state_nxt = (div_quo == '0) ? S_NEXT : S_MUL_GOT;
        end
      end
      S_MUL_GOT: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(ratio_r);
        state_nxt = S_GOT_START;
      end
      S_GOT_START: begin
        div_start = 1'b1;
        state_nxt = S_GOT_WAIT;
      end
      S_GOT_WAIT: begin
        if (div_st.done) begin
          // equal error keeps the later, larger ratio
          if (!found_r || (cur_err <= best_err_r)) begin
            best_err_nxt   = cur_err;
            best_ratio_nxt = ratio_r;
            best_dv_nxt    = dv_r;
            found_nxt      = 1'b1;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (ratio_r == RW'(MAX_RATIO)) begin
          if (fit_ok) begin
            status_nxt    = ST_OK;
            osr_nxt       = OSR_W'(osr_tmp);
            divout_nxt    = best_dv_r[DIVOUT_W-1:0];
            both_edge_nxt = (best_ratio_r >= RW'(BOTH_EDGE_MIN)) &&
                            (best_ratio_r <= RW'(BOTH_EDGE_MAX));
            enable_nxt    = 1'b1;
          end else begin
            status_nxt    = ST_NO_FIT;
            osr_nxt       = '0;
            divout_nxt    = '0;
            both_edge_nxt = 1'b0;
            enable_nxt    = 1'b0;
          end
          state_nxt = S_DONE;
        end else begin
          ratio_nxt = ratio_r + RW'(1);
          state_nxt = S_MUL_DEN;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    clk_hz_r     <= clk_hz_nxt;
    baud_r       <= baud_nxt;
    ratio_r      <= ratio_nxt;
    prod_r       <= prod_nxt;
    dv_r         <= dv_nxt;
    tol_r        <= tol_nxt;
    best_err_r   <= best_err_nxt;
    best_ratio_r <= best_ratio_nxt;
    best_dv_r    <= best_dv_nxt;
    status_r     <= status_nxt;
    osr_r        <= osr_nxt;
    divout_r     <= divout_nxt;
    both_edge_r  <= both_edge_nxt;
    enable_r     <= enable_nxt;
  end

  // handshake: busy from accept until the result is taken
  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_DONE);
  assign out_status    = status_r;
  assign out_osr_field = osr_r;
  assign out_divisor   = divout_r;
  assign out_both_edge = both_edge_r;
  assign out_enable    = enable_r;

  // divider finishes only while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_TOL_WAIT) || (state_r == S_DV_WAIT) ||
                    (state_r == S_GOT_WAIT))
    else $error("divider done outside a wait state");

  // divider is never restarted while busy
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // a rejected result carries all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_osr_field == '0) && (out_divisor == '0) && !out_both_edge && !out_enable)
    else $error("rejected result with nonzero fields");

  // an accepted result always has a usable ratio within tolerance
  a_ok_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |-> fit_ok && out_enable)
    else $error("accepted result without a fitting ratio");

endmodule

>>> rtl/ubds_serial_div.sv
// ubds_serial_div: restoring divider, one quotient bit per cycle
// depends on ubds_pkg (div_stat_t)
`timescale 1ns / 1ps

module ubds_serial_div import ubds_pkg::*; #(
  parameter int NUM_W = CLK_HZ_W,
  parameter int DEN_W = DV_W + 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output div_stat_t        stat
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift next dividend bit into the partial remainder
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> bench/uart_baud_divisor_search_test.sv
// uart_baud_divisor_search_test: self-checking bench for the baud divisor search block,
// a directed table then random requests, every result compared with a local predictor
// depends on ubds_pkg and uart_baud_divisor_search (with its serial divider)
`timescale 1ns / 1ps

module uart_baud_divisor_search_test;
  import ubds_pkg::*;

  // after the last result, let SETTLE_CYCLES pass, longer than one search
  localparam int SETTLE_CYCLES = 2000;
  localparam int NUM_DIRECTED  = 24;
  localparam int NUM_RANDOM    = 300;

  // what one result carries, in port order
  typedef struct packed {
    status_t               status;
    logic [OSR_W-1:0]      osr_field;
    logic [DIVOUT_W-1:0]   divisor;
    logic                  both_edge;
    logic                  enable;
  } baud_setting_t;

  // directed rows: typed rows carry a hand-worked answer, the rest use the predictor
  typedef struct {
    logic [KHZ_W-1:0]  khz;
    logic [BAUD_W-1:0] baud;
    bit                typed;
    baud_setting_t     want;
  } directed_row_t;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [KHZ_W-1:0]    in_clock_khz   = '0;
  logic [BAUD_W-1:0]   in_target_baud = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [OSR_W-1:0]    out_osr_field;
  logic [DIVOUT_W-1:0] out_divisor;
  logic                out_both_edge;
  logic                out_enable;

  baud_setting_t pending_settings[$];
  int unsigned   mismatch_count = 0;
  bit            quiet = 1'b0;  // no idling on either side while set

  uart_baud_divisor_search u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_clock_khz   (in_clock_khz),
    .in_target_baud (in_target_baud),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_osr_field  (out_osr_field),
    .out_divisor    (out_divisor),
    .out_both_edge  (out_both_edge),
    .out_enable     (out_enable)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor: try every ratio, keep the closest achieved rate, larger ratio on a tie
  function automatic baud_setting_t search_divisor(input logic [KHZ_W-1:0] khz,
                                                   input logic [BAUD_W-1:0] baud);
    longint unsigned clk_hz, b, den, dv, got, err, best_err, best_ratio, tol;
    bit              found;
    baud_setting_t   s;
    s          = '0;
    found      = 1'b0;
    best_err   = 0;
    best_ratio = 0;
    b          = 64'(baud);
    if (khz < CLK_KHZ_MIN || khz > CLK_KHZ_MAX) begin
      s.status = ST_CLK_RANGE;
      return s;
    end
    clk_hz = 64'(khz);
    clk_hz = clk_hz * HZ_PER_KHZ;
    for (longint unsigned r = MIN_RATIO_DEF; r <= MAX_RATIO_DEF; r++) begin
      den = b * r;
      if (den == 0) continue;  // zero baud
      dv = clk_hz / den;
      if (dv == 0) continue;   // ratio too large for this clock
      got = clk_hz / (r * dv);
      err = (got > b) ? got - b : b - got;
      if (!found || err <= best_err) begin
        best_err   = err;
        best_ratio = r;
        found      = 1'b1;
      end
    end
    // below 100 bit/s the tolerance is zero and nothing passes
    tol = (b / TOL_DIV) * TOL_MUL;
    if (!found || !(best_err < tol)) begin
      s.status = ST_NO_FIT;
      return s;
    end
    // full-width divisor during the search, low bits only on the port
    dv          = clk_hz / (b * best_ratio);
    s.status    = ST_OK;
    s.osr_field = OSR_W'(best_ratio - 1);
    s.divisor   = DIVOUT_W'(dv);
    s.both_edge = (best_ratio >= BOTH_EDGE_MIN && best_ratio <= BOTH_EDGE_MAX);
    s.enable    = 1'b1;
    return s;
  endfunction

  // extremes, every status, the special cases, then bit patterns for the predictor
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // clock out of range on both sides
    '{16'd0,     22'd9600,    1'b1, '{ST_CLK_RANGE, 5'd0, 13'd0, 1'b0, 1'b0}},
    '{16'd31,    22'd9600,    1'b1, '{ST_CLK_RANGE, 5'd0, 13'd0, 1'b0, 1'b0}},
    '{16'd50001, 22'd9600,    1'b1, '{ST_CLK_RANGE, 5'd0, 13'd0, 1'b0, 1'b0}},
    '{16'd65535, 22'd4194303, 1'b1, '{ST_CLK_RANGE, 5'd0, 13'd0, 1'b0, 1'b0}},
    // lowest clock, exact fit at the largest ratio
    '{16'd32,    22'd1000,    1'b1, '{ST_OK, 5'd31, 13'd1, 1'b0, 1'b1}},
    // ratios above 8 all give a zero divisor, ratio 8 wins the tie: both edges
    '{16'd32,    22'd4000,    1'b1, '{ST_OK, 5'd7, 13'd1, 1'b1, 1'b1}},
    // divisor 15625 wider than the port, low bits 7433
    '{16'd50000, 22'd100,     1'b1, '{ST_OK, 5'd31, 13'd7433, 1'b0, 1'b1}},
    // zero baud
    '{16'd50000, 22'd0,       1'b1, '{ST_NO_FIT, 5'd0, 13'd0, 1'b0, 1'b0}},
    // low baud: tolerance is zero
    '{16'd1000,  22'd99,      1'b1, '{ST_NO_FIT, 5'd0, 13'd0, 1'b0, 1'b0}},
    // every ratio gives a zero divisor
    '{16'd32,    22'd4194303, 1'b1, '{ST_NO_FIT, 5'd0, 13'd0, 1'b0, 1'b0}},
    // best error 166666 is over the limit
    '{16'd50000, 22'd4000000, 1'b1, '{ST_NO_FIT, 5'd0, 13'd0, 1'b0, 1'b0}},
    // exact at ratio 24, larger ratios miss
    '{16'd48000, 22'd1000000, 1'b1, '{ST_OK, 5'd23, 13'd2, 1'b0, 1'b1}},
    '{16'd50000, 22'd115200,  1'b0, '0},
    '{16'd50000, 22'd4194303, 1'b0, '0},
    '{16'd32,    22'd1,       1'b0, '0},
    '{16'd50000, 22'd1,       1'b0, '0},
    '{16'd1843,  22'd115200,  1'b0, '0},
    '{16'd24000, 22'd9600,    1'b0, '0},
    '{16'd12000, 22'd3000000, 1'b0, '0},
    '{16'd32768, 22'd2097152, 1'b0, '0},
    '{16'd43690, 22'd2796202, 1'b0, '0},
    '{16'd21845, 22'd1398101, 1'b0, '0},
    '{16'd100,   22'd3,       1'b0, '0},
    '{16'd50000, 22'd300,     1'b0, '0}
  };

  int unsigned common_bauds [16] = '{
    300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
    115200, 230400, 460800, 921600, 1000000, 2000000, 3000000, 4000000
  };

  // offer one request, hold it until taken, then queue its expected setting
  task automatic offer_request(input logic [KHZ_W-1:0] khz, input logic [BAUD_W-1:0] baud,
                               input bit typed, input baud_setting_t want);
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_clock_khz   <= khz;
    in_target_baud <= baud;
    do @(posedge clk); while (in_stall);
    pending_settings.push_back(typed ? want : search_divisor(khz, baud));
  endtask

  // sender goes quiet until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: random stall, compare each taken result with the oldest expectation
  always @(posedge clk) begin
    baud_setting_t want;
    out_stall <= !quiet && ($urandom_range(99) < 10);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_settings.size() == 0) begin
        $error("result with no request pending");
        mismatch_count++;
      end else begin
        want = pending_settings.pop_front();
        check_field("status",    32'(want.status),    32'(out_status));
        check_field("osr_field", 32'(want.osr_field), 32'(out_osr_field));
        check_field("divisor",   32'(want.divisor),   32'(out_divisor));
        check_field("both_edge", 32'(want.both_edge), 32'(out_both_edge));
        check_field("enable",    32'(want.enable),    32'(out_enable));
      end
    end
  end

  // stimulus
  initial begin
    logic [KHZ_W-1:0]  khz;
    logic [BAUD_W-1:0] baud;
    int unsigned       pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      offer_request(directed_rows[i].khz, directed_rows[i].baud,
                    directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // a stretch with no idling on either side
      quiet = (i >= 200 && i < 260);
      if (i == 150) drain_results();
      pick = $urandom_range(99);
      if (pick < 60) begin
        // usable clock and a standard rate, mostly accepted
        khz  = KHZ_W'($urandom_range(CLK_KHZ_MIN, CLK_KHZ_MAX));
        baud = BAUD_W'(common_bauds[$urandom_range(15)]);
      end else if (pick < 80) begin
        khz  = KHZ_W'($urandom_range(CLK_KHZ_MIN, CLK_KHZ_MAX));
        baud = BAUD_W'($urandom_range(100, 4000000));
      end else if (pick < 90) begin
        khz  = $urandom_range(1) ? KHZ_W'($urandom_range(0, CLK_KHZ_MIN - 1))
                                 : KHZ_W'($urandom_range(CLK_KHZ_MAX + 1, 65535));
        baud = BAUD_W'($urandom);
      end else begin
        // raw noise over the full field widths
        khz  = KHZ_W'($urandom);
        baud = BAUD_W'($urandom);
      end
      offer_request(khz, baud, 1'b0, '0);
    end
    quiet = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_settings.size() == 0)
      $display("uart_baud_divisor_search_test passed");
    else
      $display("uart_baud_divisor_search_test failed");
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #(15_000_000);
    $display("uart_baud_divisor_search_test failed");
    $finish;
  end

endmodule
